// ===== rtl/core/mhu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the mail header unfolder.
// No dependencies; every other file in rtl/core imports this package.
package mhu_pkg;

   localparam int DEFAULT_COUNT_WIDTH = 32;
   localparam int DEFAULT_QUEUE_DEPTH = 4;
   localparam int OUT_COUNT_WIDTH     = 32;

   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;

   localparam logic FUNC_DATA = 1'b0;
   localparam logic FUNC_EOI  = 1'b1;

   // Result slots of one request, in emission order
   localparam int SLOT_END  = 0;
   localparam int SLOT_CR   = 1;
   localparam int SLOT_BYTE = 2;
   localparam int SLOT_TERM = 3;
   localparam int NUM_SLOTS = 4;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]                 out_byte;
      logic                       byte_valid;
      logic                       line_end;
      logic                       headers_done;
      logic                       format_error;
      logic [OUT_COUNT_WIDTH-1:0] consumed_count;
      logic                       last_of_run;
   } rsp_payload_type;

   // Everything one request produces, as queued between front and back
   typedef struct packed {
      logic [NUM_SLOTS-1:0]       slots;
      logic [7:0]                 data;
      logic                       term_err;
      logic [OUT_COUNT_WIDTH-1:0] count;
   } bundle_type;

endpackage

// ===== rtl/core/mhu_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests, tracks line state and classifies each byte
// into a bundle of results. Depends on mhu_pkg.
module mhu_front import mhu_pkg::*; #(
   parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  req_payload_type req_payload,
   output logic            req_stall,
   input  logic            queue_full,
   output logic            push,
   output bundle_type      push_bundle
);

   typedef enum logic [3:0] {
      PH_FIRST = 4'b0001,
      PH_START = 4'b0010,
      PH_BODY  = 4'b0100,
      PH_SKIP  = 4'b1000
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic                   cr_held_ff, cr_held_in;
   logic                   nonempty_ff, nonempty_in;
   logic                   first_line_ff, first_line_in;
   logic [COUNT_WIDTH-1:0] counter_ff, counter_in;
   logic [COUNT_WIDTH-1:0] counter_inc;
   logic [COUNT_WIDTH+OUT_COUNT_WIDTH-1:0] count_wide;

   logic       accept;
   logic [7:0] b;
   logic       is_blank;
   logic       emit_end, emit_cr, emit_byte, emit_term, go_body, clear;
   logic [7:0] byte_val;

   assign req_stall   = queue_full;
   assign accept      = req_valid && !req_stall;
   assign b           = req_payload.data_byte;
   assign is_blank    = (b == CH_SP) || (b == CH_TAB);
   // saturate at all ones
   assign counter_inc = (counter_ff != {COUNT_WIDTH{1'b1}}) ? counter_ff + COUNT_WIDTH'(1)
                                                            : counter_ff;
   assign count_wide  = {{OUT_COUNT_WIDTH{1'b0}}, counter_inc};

   always_comb begin
      phase_in      = phase_ff;
      cr_held_in    = cr_held_ff;
      nonempty_in   = nonempty_ff;
      first_line_in = first_line_ff;
      counter_in    = counter_ff;
      emit_end      = 1'b0;
      emit_cr       = 1'b0;
      emit_byte     = 1'b0;
      emit_term     = 1'b0;
      go_body       = 1'b0;
      clear         = 1'b0;
      byte_val      = b;
      push_bundle   = '0;
      if (req_payload.func == FUNC_EOI) begin
         emit_term            = 1'b1;
         push_bundle.term_err = !first_line_ff;
         clear                = 1'b1;
      end else begin
         first_line_in = 1'b0;
         counter_in    = counter_inc;
         case (phase_ff)
            PH_FIRST, PH_BODY: begin
               go_body = 1'b1;
            end
            PH_SKIP: begin
               go_body = !is_blank;
            end
            PH_START: begin
               if (b == CH_LF) begin
                  // blank line: close the block
                  emit_end          = nonempty_ff;
                  emit_term         = 1'b1;
                  push_bundle.count = count_wide[OUT_COUNT_WIDTH-1:0];
                  clear             = 1'b1;
               end else if (cr_held_ff) begin
                  emit_end = 1'b1;
                  go_body  = 1'b1;
               end else if (b == CH_CR) begin
                  cr_held_in = 1'b1;
               end else if (is_blank) begin
                  // folded line: run of blanks becomes one space
                  emit_byte = 1'b1;
                  byte_val  = CH_SP;
                  phase_in  = PH_SKIP;
               end else begin
                  emit_end = 1'b1;
                  go_body  = 1'b1;
               end
            end
            default: begin
               phase_in = PH_FIRST;
            end
         endcase
         if (go_body) begin
            phase_in   = PH_BODY;
            emit_cr    = cr_held_ff && (b != CH_LF);
            cr_held_in = (b == CH_CR);
            if (b == CH_LF) begin
               phase_in = PH_START;
            end else if (b != CH_CR) begin
               emit_byte = 1'b1;
            end
         end
         if (emit_cr || emit_byte) begin
            nonempty_in = 1'b1;
         end else if (emit_end) begin
            nonempty_in = 1'b0;
         end
      end
      if (clear) begin
         phase_in      = PH_FIRST;
         cr_held_in    = 1'b0;
         nonempty_in   = 1'b0;
         first_line_in = 1'b1;
         counter_in    = '0;
      end
      push_bundle.slots[SLOT_END]  = emit_end;
      push_bundle.slots[SLOT_CR]   = emit_cr;
      push_bundle.slots[SLOT_BYTE] = emit_byte;
      push_bundle.slots[SLOT_TERM] = emit_term;
      push_bundle.data             = byte_val;
   end

   // Only requests that produce results enter the queue
   assign push = accept && (push_bundle.slots != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FIRST;
         cr_held_ff    <= 1'b0;
         nonempty_ff   <= 1'b0;
         first_line_ff <= 1'b1;
         counter_ff    <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         cr_held_ff    <= cr_held_in;
         nonempty_ff   <= nonempty_in;
         first_line_ff <= first_line_in;
         counter_ff    <= counter_in;
      end
   end

   a_eoi_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.func == FUNC_EOI
      |=> phase_ff == PH_FIRST && first_line_ff && counter_ff == '0)
      else $error("front state not cleared after end of input");

   a_term_alone: assert property (@(posedge clock) disable iff (reset)
      push && push_bundle.slots[SLOT_TERM]
      |-> !push_bundle.slots[SLOT_CR] && !push_bundle.slots[SLOT_BYTE])
      else $error("termination bundled with header data");

endmodule

// ===== rtl/core/mhu_queue.sv =====
`timescale 1ns / 1ps
// Short bundle queue decoupling the front end from the result sequencer.
// Depends on mhu_pkg.
module mhu_queue import mhu_pkg::*; #(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_bundle,
   input  logic       pop,
   output bundle_type head,
   output logic       empty,
   output logic       full
);

   localparam int PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);

   bundle_type          store_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] fill_ff, fill_in;
   logic                do_push, do_pop;

   assign empty   = (fill_ff == '0);
   assign full    = (fill_ff == CntWidth'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CntWidth'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

endmodule

// ===== rtl/core/mhu_back.sv =====
`timescale 1ns / 1ps
// Back end: walks the slots of the head bundle and presents one result per
// cycle while not stalled, via a registered output stage. Depends on mhu_pkg.
module mhu_back import mhu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  bundle_type      head,
   input  logic            empty,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic [NUM_SLOTS-1:0] sent_ff, sent_in;
   logic [NUM_SLOTS-1:0] pending, sel, rest;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff, rsp_payload_in;
   logic                 load, advance;

   assign pending = empty ? '0 : (head.slots & ~sent_ff);
   assign sel     = pending & (~pending + NUM_SLOTS'(1));
   assign rest    = pending & ~sel;
   assign load    = !rsp_valid_ff || !rsp_stall;
   assign advance = load && (pending != '0);
   assign pop     = advance && (rest == '0);

   always_comb begin
      sent_in = sent_ff;
      if (pop) begin
         sent_in = '0;
      end else if (advance) begin
         sent_in = sent_ff | sel;
      end
      rsp_valid_in = advance ? 1'b1 : (load ? 1'b0 : rsp_valid_ff);

      rsp_payload_in              = '0;
      rsp_payload_in.byte_valid   = sel[SLOT_CR] || sel[SLOT_BYTE];
      rsp_payload_in.line_end     = sel[SLOT_END];
      rsp_payload_in.headers_done = sel[SLOT_TERM] && !head.term_err;
      rsp_payload_in.format_error = sel[SLOT_TERM] && head.term_err;
      rsp_payload_in.last_of_run  = (rest == '0);
      if (sel[SLOT_CR]) begin
         rsp_payload_in.out_byte = CH_CR;
      end else if (sel[SLOT_BYTE]) begin
         rsp_payload_in.out_byte = head.data;
      end
      if (sel[SLOT_TERM] && !head.term_err) begin
         rsp_payload_in.consumed_count = head.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold payload while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot({rsp_payload_ff.byte_valid, rsp_payload_ff.line_end,
                                rsp_payload_ff.headers_done, rsp_payload_ff.format_error}))
      else $error("result carries more than one kind");

   a_pop_ends_run: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff && rsp_payload_ff.last_of_run)
      else $error("bundle released without closing its run");

endmodule

// ===== rtl/core/mail_header_unfolder.sv =====
`timescale 1ns / 1ps
// Mail header unfolder top level: front end, bundle queue, result sequencer.
// Depends on mhu_pkg, mhu_front, mhu_queue, mhu_back.
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/stall     req_payload_type (func, data_byte)
//   rsp_      out        rsp_valid/stall     rsp_payload_type (one result each)
//
// A request is classified in the cycle it is accepted; up to three
// results follow via the queue and output register, one per unstalled cycle.
// Requests are taken every cycle while the bundle queue has room; sustained
// rate is set by the one-result-per-cycle output register.
// Reset is synchronous and clears line state, the counter and the queue.
// A stall on rsp_ holds the output register; requests keep entering until
// the queue fills, then req_stall rises.
module mail_header_unfolder import mhu_pkg::*; #(
   parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH,
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic       push, pop, empty, full;
   bundle_type push_bundle, head;

   mhu_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .queue_full  (full),
      .push        (push),
      .push_bundle (push_bundle)
   );

   mhu_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head        (head),
      .empty       (empty),
      .full        (full)
   );

   mhu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
